### rtl/hng_pkg.sv
// ----------------------------------------------------------------------------
// hng_pkg: shared types and constants for the heightmap normal generator
// Grid limits, field widths, register map and the stage records.
// ----------------------------------------------------------------------------
package hng_pkg;

	localparam int MAX_SIDE   = 1024;
	localparam int COORD_W    = $clog2(MAX_SIDE);
	localparam int SIDE_W     = COORD_W + 1;
	localparam int HEIGHT_W   = 16;
	localparam int SLOPE_W    = HEIGHT_W + 1;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int OUT_BITS   = 2 * COORD_W + 2 * SLOPE_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
	localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
	localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;

	localparam logic [APB_ADDR_W-1:0] ADDR_GRID_SIDE = APB_ADDR_W'(0);

	typedef logic [COORD_W-1:0]         coord_t;
	typedef logic [SIDE_W-1:0]          side_t;
	typedef logic signed [HEIGHT_W-1:0] height_t;
	typedef logic signed [SLOPE_W-1:0]  slope_t;

	// one accepted item that changes state, held between the two register ranks
	typedef struct packed {
		logic    emit;
		logic    wr;
		logic    first_col;
		logic    last_col;
		logic    down_mid;
		logic    last_frame;
		coord_t  col;
		coord_t  row;
		height_t height;
	} stage_t;

	typedef struct packed {
		logic   rd_en;
		coord_t addr_mid;
		coord_t addr_right;
	} rd_req_t;

	typedef struct packed {
		logic    wr_en;
		coord_t  addr;
		height_t newer;
		height_t older;
	} wr_req_t;

	typedef struct packed {
		height_t mid;
		height_t right;
		height_t older;
	} rd_data_t;

	function automatic slope_t height_diff(input height_t a, input height_t b);
		slope_t ext_a;
		slope_t ext_b;
		ext_a = slope_t'(a);
		ext_b = slope_t'(b);
		return ext_a - ext_b;
	endfunction

endpackage

### rtl/heightmap_normal_generator.sv
// ----------------------------------------------------------------------------
// heightmap_normal_generator: central-difference normals of a raster heightmap
// Top level: APB register, input stream of samples and flush ticks, result stream.
// ----------------------------------------------------------------------------
// Input beats carry a signed Q8.8 height in s_tdata and the kind in s_tuser
// (0 = sample, 1 = flush tick). Samples arrive row by row, column fastest.
// A sample in row r >= 1 completes the point one row above it; row 0 only
// fills the line store. After the last sample, one flush tick per column
// emits the final row; the last flush beat carries m_tlast and opens a new
// frame. Samples past the frame end and flush ticks before it are dropped.
// Each result beat gives col, row, slope_x (left - right) and slope_z
// (upper row - lower row), edges clamped, not normalized.
// The input beat and its line reads are registered in stage_s1, then the
// result in m_tdata; m_tvalid rises when that stage advances.
// Throughput: one beat per cycle unless the output stalls; each item reads
// the newer line memory twice and each sample writes it once (1024 x 16,
// registered reads, write forwarding), so nothing waits on the memories.
// Reset sets grid_side to 256 and restarts the frame; the line memories are
// not cleared and need none. A stalled output holds its beat while one more
// item sits in the input register; beyond that s_tready falls.
// Write grid_side only while idle; the write restarts the frame.
// ----------------------------------------------------------------------------
module heightmap_normal_generator import hng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [HEIGHT_W-1:0]   s_tdata,   // height
	input  logic                  s_tuser,   // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // col, row, slope_x, slope_z, zero pad
	output logic                  m_tlast    // last_of_frame
);

	logic     valid_s1;
	stage_t   stage_s1;
	rd_req_t  rd_req;
	wr_req_t  wr_req;
	rd_data_t rd_data;
	logic     adv;

	assign pready   = 1'b1;
	assign s_tready = !valid_s1 || adv;

	hng_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.rd_req   (rd_req)
	);

	hng_lines u_lines (
		.clk     (clk),
		.rd_req  (rd_req),
		.wr_req  (wr_req),
		.rd_data (rd_data)
	);

	hng_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.rd_data  (rd_data),
		.m_tready (m_tready),
		.adv      (adv),
		.wr_req   (wr_req),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### rtl/hng_lines.sv
// ----------------------------------------------------------------------------
// hng_lines: the two line stores
// Newer and older row memories with registered reads and write forwarding.
// ----------------------------------------------------------------------------
module hng_lines import hng_pkg::*; (
	input  logic     clk,
	input  rd_req_t  rd_req,
	input  wr_req_t  wr_req,
	output rd_data_t rd_data
);

	height_t newer_mem [MAX_SIDE];
	height_t older_mem [MAX_SIDE];

	height_t mid_q;
	height_t right_q;
	height_t older_q;
	logic    byp_mid_q;
	logic    byp_right_q;
	logic    byp_older_q;
	height_t byp_newer_q;
	height_t byp_older_data_q;

	always_ff @(posedge clk) begin
		if (wr_req.wr_en) begin
			newer_mem[wr_req.addr] <= wr_req.newer;
			older_mem[wr_req.addr] <= wr_req.older;
		end
	end

	// a write landing on the same edge as a read is forwarded instead
	always_ff @(posedge clk) begin
		if (rd_req.rd_en) begin
			mid_q            <= newer_mem[rd_req.addr_mid];
			right_q          <= newer_mem[rd_req.addr_right];
			older_q          <= older_mem[rd_req.addr_mid];
			byp_mid_q        <= wr_req.wr_en && (wr_req.addr == rd_req.addr_mid);
			byp_right_q      <= wr_req.wr_en && (wr_req.addr == rd_req.addr_right);
			byp_older_q      <= wr_req.wr_en && (wr_req.addr == rd_req.addr_mid);
			byp_newer_q      <= wr_req.newer;
			byp_older_data_q <= wr_req.older;
		end
	end

	always_comb begin
		rd_data.mid   = byp_mid_q ? byp_newer_q : mid_q;
		rd_data.right = byp_right_q ? byp_newer_q : right_q;
		rd_data.older = byp_older_q ? byp_older_data_q : older_q;
	end

endmodule

### rtl/hng_seq.sv
// ----------------------------------------------------------------------------
// hng_seq: raster position tracking and input stage
// Holds grid_side, counts samples and flush ticks, issues line reads.
// ----------------------------------------------------------------------------
module hng_seq import hng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [HEIGHT_W-1:0]   s_tdata,
	input  logic                  s_tuser,
	output logic                  valid_s1,
	output stage_t                stage_s1,
	output rd_req_t               rd_req
);

	side_t  grid_side_q;
	coord_t in_col_q;
	side_t  in_row_q;
	coord_t flush_col_q;

	side_t  side_eff;
	coord_t side_m1;
	logic   is_flush;
	coord_t col_sel;
	logic   last_col;
	logic   frame_full;
	logic   take;
	logic   cfg_wr;

	always_comb begin
		if (grid_side_q < SIDE_MIN) begin
			side_eff = SIDE_MIN;
		end else if (grid_side_q > SIDE_MAX) begin
			side_eff = SIDE_MAX;
		end else begin
			side_eff = grid_side_q;
		end
	end

	assign side_m1    = COORD_W'(side_eff - SIDE_W'(1));
	assign is_flush   = (s_tuser == KIND_FLUSH);
	assign col_sel    = is_flush ? flush_col_q : in_col_q;
	assign last_col   = (col_sel == side_m1);
	assign frame_full = (in_row_q >= side_eff);
	// drop samples past the frame end and flush ticks before it
	assign take       = s_tvalid && s_tready && (is_flush ? frame_full : !frame_full);
	assign cfg_wr     = psel && penable && pwrite && (paddr == ADDR_GRID_SIDE);
	assign prdata     = APB_DATA_W'(grid_side_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_RESET;
			in_col_q    <= '0;
			in_row_q    <= '0;
			flush_col_q <= '0;
		end else if (cfg_wr) begin
			grid_side_q <= pwdata[SIDE_W-1:0];
			in_col_q    <= '0;
			in_row_q    <= '0;
			flush_col_q <= '0;
		end else if (take) begin
			if (is_flush) begin
				if (last_col) begin
					flush_col_q <= '0;
					in_col_q    <= '0;
					in_row_q    <= '0;
				end else begin
					flush_col_q <= flush_col_q + COORD_W'(1);
				end
			end else if (last_col) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + SIDE_W'(1);
			end else begin
				in_col_q <= in_col_q + COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			stage_s1.emit       <= is_flush || (in_row_q != '0);
			stage_s1.wr         <= !is_flush;
			stage_s1.first_col  <= (col_sel == '0);
			stage_s1.last_col   <= last_col;
			stage_s1.down_mid   <= !is_flush && (in_row_q == SIDE_W'(1));
			stage_s1.last_frame <= is_flush && last_col;
			stage_s1.col        <= col_sel;
			stage_s1.row        <= is_flush ? side_m1 : COORD_W'(in_row_q - SIDE_W'(1));
			stage_s1.height     <= height_t'(s_tdata);
		end
	end

	always_comb begin
		rd_req.rd_en      = take;
		rd_req.addr_mid   = col_sel;
		rd_req.addr_right = last_col ? col_sel : col_sel + COORD_W'(1);
	end

endmodule

### rtl/hng_emit.sv
// ----------------------------------------------------------------------------
// hng_emit: slope arithmetic and result register
// Picks clamped neighbors, forms both differences, writes back the lines.
// ----------------------------------------------------------------------------
module hng_emit import hng_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  stage_t                stage_s1,
	input  rd_data_t              rd_data,
	input  logic                  m_tready,
	output logic                  adv,
	output wr_req_t               wr_req,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	height_t held_q;
	height_t left;
	height_t right;
	height_t down;
	height_t up;
	slope_t  slope_x;
	slope_t  slope_z;
	logic    load;

	assign adv  = valid_s1 && (!stage_s1.emit || !m_tvalid || m_tready);
	assign load = adv && stage_s1.emit;

	always_comb begin
		left    = stage_s1.first_col ? rd_data.mid : held_q;
		right   = stage_s1.last_col ? rd_data.mid : rd_data.right;
		down    = stage_s1.down_mid ? rd_data.mid : rd_data.older;
		up      = stage_s1.wr ? stage_s1.height : rd_data.mid;
		slope_x = height_diff(left, right);
		slope_z = height_diff(down, up);
	end

	always_comb begin
		wr_req.wr_en = adv && stage_s1.wr;
		wr_req.addr  = stage_s1.col;
		wr_req.newer = stage_s1.height;
		wr_req.older = rd_data.mid;
	end

	// keep the previous row's value of this column as the next left neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (adv) begin
			held_q <= rd_data.mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= OUT_DATA_W'({slope_z, slope_x, stage_s1.row, stage_s1.col});
			m_tlast <= stage_s1.last_frame;
		end
	end

endmodule

### rtl/hng_checker.sv
// ----------------------------------------------------------------------------
// hng_checker: port-level checks for the heightmap normal generator
// Watches the result stream; bound to the top level below.
// ----------------------------------------------------------------------------
module hng_checker import hng_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// the final point of a frame sits on the diagonal corner
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[COORD_W-1:0] == m_tdata[2*COORD_W-1:COORD_W])
		else $error("frame end beat not at the last corner");

	// differences of two heights never reach the most negative code
	a_slope_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2*COORD_W+SLOPE_W-1:2*COORD_W] != {1'b1, {(SLOPE_W-1){1'b0}}}
			&& m_tdata[2*COORD_W+2*SLOPE_W-1:2*COORD_W+SLOPE_W]
				!= {1'b1, {(SLOPE_W-1){1'b0}}})
		else $error("slope out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_BITS] == '0)
		else $error("padding bits of result beat not zero");

endmodule

bind heightmap_normal_generator hng_checker u_hng_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
